/* rtl/lbcd_pkg.sv */
`default_nettype none

package lbcd_pkg;

    // Parameter defaults for the top level.
    localparam int WAYS_DEF       = 8;
    localparam int TAG_BITS_DEF   = 32;
    localparam int STAMP_BITS_DEF = 32;

    // Fixed field widths of the stream payloads.
    localparam int CMD_W       = 2;
    localparam int ADDR_W      = 32;
    localparam int WAY_W       = 3;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    // Request command codes.
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // Control flags of the token that walks down the row of ways.
    typedef struct packed {
        logic tok_valid;  // a token occupies this stage
        logic is_flush;   // flush token, otherwise a lookup token
        logic last;       // final result of the request
        logic hit;        // a way matched the tag so far
        logic inv;        // an invalid way was seen so far
        logic have;       // a valid minimum candidate is held
        logic min_dirty;  // candidate is dirty (flush: writeback needed)
    } t_tok_flags;

    // Update broadcast from the tail of the row back into the ways.
    typedef struct packed {
        logic en;     // apply at this edge
        logic alloc;  // miss fill, otherwise a hit refresh
        logic write;  // write request
    } t_upd;

endpackage

`default_nettype wire

/* rtl/lbcd_cell.sv */
`default_nettype none

module lbcd_cell
    import lbcd_pkg::*;
#(
    parameter int IDX_W      = 3,
    parameter int TAG_BITS   = TAG_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF,
    parameter int CELL_IDX   = 0
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_adv,
    input  t_tok_flags            i_flags,
    input  wire [IDX_W-1:0]       i_idx,
    input  wire [IDX_W-1:0]       i_hit_way,
    input  wire [IDX_W-1:0]       i_inv_way,
    input  wire [IDX_W-1:0]       i_min_way,
    input  wire [STAMP_BITS-1:0]  i_min_stamp,
    input  wire [TAG_BITS-1:0]    i_min_tag,
    input  wire [TAG_BITS-1:0]    i_req_tag,
    input  t_upd                  i_upd,
    input  wire [IDX_W-1:0]       i_upd_way,
    input  wire [STAMP_BITS-1:0]  i_upd_stamp,
    output t_tok_flags            o_flags,
    output logic [IDX_W-1:0]      o_idx,
    output logic [IDX_W-1:0]      o_hit_way,
    output logic [IDX_W-1:0]      o_inv_way,
    output logic [IDX_W-1:0]      o_min_way,
    output logic [STAMP_BITS-1:0] o_min_stamp,
    output logic [TAG_BITS-1:0]   o_min_tag
);

    localparam logic [IDX_W-1:0] MY_WAY = IDX_W'(CELL_IDX);

    // Way state.
    logic                  r_valid;
    logic                  r_dirty;
    logic [TAG_BITS-1:0]   r_tag;
    logic [STAMP_BITS-1:0] r_stamp;

    // Token stage handed to the next cell.
    t_tok_flags            r_flags, n_flags;
    logic [IDX_W-1:0]      r_idx, r_hit_way, r_inv_way, r_min_way;
    logic [IDX_W-1:0]      n_hit_way, n_inv_way, n_min_way;
    logic [STAMP_BITS-1:0] r_min_stamp, n_min_stamp;
    logic [TAG_BITS-1:0]   r_min_tag, n_min_tag;

    logic lookup, flush_here, upd_here;

    assign lookup     = i_flags.tok_valid && !i_flags.is_flush;
    assign flush_here = i_flags.tok_valid && i_flags.is_flush && (i_idx == MY_WAY);
    assign upd_here   = i_upd.en && (i_upd_way == MY_WAY);

    // Fold this way into the hit, first-invalid and oldest-stamp search or flush.
    always_comb begin
        n_flags     = i_flags;
        n_hit_way   = i_hit_way;
        n_inv_way   = i_inv_way;
        n_min_way   = i_min_way;
        n_min_stamp = i_min_stamp;
        n_min_tag   = i_min_tag;
        if (lookup) begin
            if (!i_flags.hit && r_valid && (r_tag == i_req_tag)) begin
                n_flags.hit = 1'b1;
                n_hit_way   = MY_WAY;
            end
            if (!i_flags.inv && !r_valid) begin
                n_flags.inv = 1'b1;
                n_inv_way   = MY_WAY;
            end
            if (r_valid && (!i_flags.have || (r_stamp < i_min_stamp))) begin
                n_flags.have      = 1'b1;
                n_flags.min_dirty = r_dirty;
                n_min_way         = MY_WAY;
                n_min_stamp       = r_stamp;
                n_min_tag         = r_tag;
            end
        end
        if (flush_here) begin
            n_flags.min_dirty = r_valid && r_dirty;
            n_min_tag         = r_tag;
        end
    end

    // Token stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_adv) begin
            r_flags <= n_flags;
        end
    end

    // Token stage payload.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_idx       <= i_idx;
            r_hit_way   <= n_hit_way;
            r_inv_way   <= n_inv_way;
            r_min_way   <= n_min_way;
            r_min_stamp <= n_min_stamp;
            r_min_tag   <= n_min_tag;
        end
    end

    // Valid and dirty marks: flush clears dirty, the tail update sets valid and updates dirty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
        end else if (upd_here) begin
            r_valid <= 1'b1;
            r_dirty <= i_upd.alloc ? i_upd.write : (r_dirty || i_upd.write);
        end else if (i_adv && flush_here) begin
            r_dirty <= 1'b0;
        end
    end

    // Tag and stamp.
    always_ff @(posedge i_clk) begin
        if (upd_here) begin
            r_stamp <= i_upd_stamp;
            if (i_upd.alloc) begin
                r_tag <= i_req_tag;
            end
        end
    end

    assign o_flags     = r_flags;
    assign o_idx       = r_idx;
    assign o_hit_way   = r_hit_way;
    assign o_inv_way   = r_inv_way;
    assign o_min_way   = r_min_way;
    assign o_min_stamp = r_min_stamp;
    assign o_min_tag   = r_min_tag;

endmodule

`default_nettype wire

/* rtl/lru_block_cache_directory_unit.sv */
// Directory of a fully associative write-back block cache with LRU replacement.
//
// Requests enter on the slave stream (i_s_*), one per accepted beat: read, write,
// flush, or the unused code, which is taken and dropped. Results leave on the master
// stream (o_m_*): one result for a read or write, one per way for a flush, with
// o_m_tlast on the final result of each request.
//
// The ways sit in a row of cells. A request sends tokens down the row, one cell per
// cycle while the receiver does not stall; each cell folds its way into the running
// hit and victim search, and the token leaving the last cell yields the result and
// updates the chosen way. A read or write result goes from the request registers
// through every cell to the output register; a flush gives one result per cycle
// after the first while not stalled. One request is in the directory at a time;
// o_s_tready returns the cycle after the last result of the current request has
// been registered for output, so no new read or write is taken before then.
//
// A single output register holds the next result. While the receiver stalls, the
// whole row of cells holds still and nothing is lost. Synchronous reset clears all
// valid and dirty marks, the stamp counter and every token; no clearing pass is needed.
`default_nettype none

module lru_block_cache_directory_unit
    import lbcd_pkg::*;
#(
    parameter int WAYS       = WAYS_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    // cmd[1:0], block_addr[33:2], file_blocks[65:34], zero[71:66]
    input  wire [IN_TDATA_W-1:0]   i_s_tdata,
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    // way[2:0], hit[3], writeback[4], writeback_addr[36:5], load[37], zero[39:38]
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast
);

    localparam int IDX_W = $clog2(WAYS);
    localparam logic [IDX_W-1:0] LAST_WAY = IDX_W'(WAYS - 1);

    // Input fields.
    logic [CMD_W-1:0]          in_cmd;
    logic [ADDR_W-1:0]         in_block_addr, in_file_blocks;
    logic [TAG_BITS+ADDR_W-1:0] in_addr_ext;
    logic                      in_accept;

    assign in_cmd         = i_s_tdata[1:0];
    assign in_block_addr  = i_s_tdata[33:2];
    assign in_file_blocks = i_s_tdata[65:34];
    assign in_addr_ext    = {{TAG_BITS{1'b0}}, in_block_addr};
    assign in_accept      = i_s_tvalid && o_s_tready;

    // Request and control registers.
    logic                  r_busy, r_inj_pend, r_is_flush, r_write, r_below;
    logic [IDX_W-1:0]      r_inj_idx;
    logic [TAG_BITS-1:0]   r_tag;
    logic [STAMP_BITS-1:0] r_stamp_cnt, n_stamp_cnt;

    // Output register.
    logic              r_ovalid, r_o_hit, r_o_wb, r_o_load, r_o_last;
    logic [WAY_W-1:0]  r_o_way;
    logic [ADDR_W-1:0] r_o_wba;

    // Row of cells: stage k feeds cell k, stage WAYS is the tail.
    t_tok_flags            st_flags     [WAYS+1];
    logic [IDX_W-1:0]      st_idx       [WAYS+1];
    logic [IDX_W-1:0]      st_hit_way   [WAYS+1];
    logic [IDX_W-1:0]      st_inv_way   [WAYS+1];
    logic [IDX_W-1:0]      st_min_way   [WAYS+1];
    logic [STAMP_BITS-1:0] st_min_stamp [WAYS+1];
    logic [TAG_BITS-1:0]   st_min_tag   [WAYS+1];

    logic       adv;
    t_tok_flags tail;
    t_upd       upd;
    logic [IDX_W-1:0] upd_way;

    // The row moves whenever the output register can take a result.
    assign adv  = !r_ovalid || i_m_tready;
    assign tail = st_flags[WAYS];

    assign o_s_tready = !r_busy;

    // Token injection at the head of the row.
    always_comb begin
        st_flags[0]           = '0;
        st_flags[0].tok_valid = r_inj_pend;
        st_flags[0].is_flush  = r_is_flush;
        st_flags[0].last      = !r_is_flush || (r_inj_idx == LAST_WAY);
        st_idx[0]             = r_inj_idx;
        st_hit_way[0]         = '0;
        st_inv_way[0]         = '0;
        st_min_way[0]         = '0;
        st_min_stamp[0]       = '0;
        st_min_tag[0]         = '0;
    end

    genvar g;
    generate
        for (g = 0; g < WAYS; g++) begin : g_cell
            lbcd_cell #(
                .IDX_W      (IDX_W),
                .TAG_BITS   (TAG_BITS),
                .STAMP_BITS (STAMP_BITS),
                .CELL_IDX   (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_adv       (adv),
                .i_flags     (st_flags[g]),
                .i_idx       (st_idx[g]),
                .i_hit_way   (st_hit_way[g]),
                .i_inv_way   (st_inv_way[g]),
                .i_min_way   (st_min_way[g]),
                .i_min_stamp (st_min_stamp[g]),
                .i_min_tag   (st_min_tag[g]),
                .i_req_tag   (r_tag),
                .i_upd       (upd),
                .i_upd_way   (upd_way),
                .i_upd_stamp (n_stamp_cnt),
                .o_flags     (st_flags[g+1]),
                .o_idx       (st_idx[g+1]),
                .o_hit_way   (st_hit_way[g+1]),
                .o_inv_way   (st_inv_way[g+1]),
                .o_min_way   (st_min_way[g+1]),
                .o_min_stamp (st_min_stamp[g+1]),
                .o_min_tag   (st_min_tag[g+1])
            );
        end
    endgenerate

    // Result and way update from the token leaving the row.
    logic [IDX_W-1:0]            res_way;
    logic [IDX_W+WAY_W-1:0]      res_way_ext;
    logic [TAG_BITS+ADDR_W-1:0]  res_tag_ext;
    logic                        res_hit, res_wb, res_load;
    logic                        tail_lookup;

    assign tail_lookup = tail.tok_valid && !tail.is_flush;
    assign n_stamp_cnt = STAMP_BITS'(r_stamp_cnt + 1'b1);
    assign res_tag_ext = {{ADDR_W{1'b0}}, st_min_tag[WAYS]};
    assign res_way_ext = {{WAY_W{1'b0}}, res_way};

    always_comb begin
        res_hit  = 1'b0;
        res_wb   = 1'b0;
        res_load = 1'b0;
        res_way  = st_idx[WAYS];
        if (tail.is_flush) begin
            res_wb = tail.min_dirty;
        end else if (tail.hit) begin
            res_hit = 1'b1;
            res_way = st_hit_way[WAYS];
        end else if (tail.inv) begin
            res_way  = st_inv_way[WAYS];
            res_load = !r_write || r_below;
        end else begin
            res_way  = st_min_way[WAYS];
            res_wb   = tail.min_dirty;
            res_load = !r_write || r_below;
        end
        upd.en    = adv && tail_lookup;
        upd.alloc = !tail.hit;
        upd.write = r_write;
        upd_way   = res_way;
    end

    // Request capture, token injection and busy tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_inj_pend  <= 1'b0;
            r_stamp_cnt <= '0;
        end else begin
            if (in_accept && (in_cmd != CMD_NONE)) begin
                r_busy     <= 1'b1;
                r_inj_pend <= 1'b1;
            end else begin
                if (adv && r_inj_pend && (!r_is_flush || (r_inj_idx == LAST_WAY))) begin
                    r_inj_pend <= 1'b0;
                end
                if (adv && tail.tok_valid && tail.last) begin
                    r_busy <= 1'b0;
                end
            end
            if (upd.en) begin
                r_stamp_cnt <= n_stamp_cnt;
            end
        end
    end

    // Request payload and flush way counter.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_is_flush <= (in_cmd == CMD_FLUSH);
            r_write    <= (in_cmd == CMD_WRITE);
            r_below    <= (in_block_addr < in_file_blocks);
            r_tag      <= in_addr_ext[TAG_BITS-1:0];
            r_inj_idx  <= '0;
        end else if (adv && r_inj_pend && r_is_flush && (r_inj_idx != LAST_WAY)) begin
            r_inj_idx <= IDX_W'(r_inj_idx + 1'b1);
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= tail.tok_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (adv && tail.tok_valid) begin
            r_o_way  <= res_way_ext[WAY_W-1:0];
            r_o_hit  <= res_hit;
            r_o_wb   <= res_wb;
            r_o_wba  <= res_wb ? res_tag_ext[ADDR_W-1:0] : '0;
            r_o_load <= res_load;
            r_o_last <= tail.last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {2'b00, r_o_load, r_o_wba, r_o_wb, r_o_hit, r_o_way};

endmodule

`default_nettype wire

/* rtl/lbcd_checker.sv */
`default_nettype none

module lbcd_checker
    import lbcd_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_s_tvalid,
    input wire                   o_s_tready,
    input wire [IN_TDATA_W-1:0]  i_s_tdata,
    input wire                   o_m_tvalid,
    input wire                   i_m_tready,
    input wire [OUT_TDATA_W-1:0] o_m_tdata,
    input wire                   o_m_tlast
);

    // A stalled result holds its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // A hit never asks for writeback or load and ends its request.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[3] |-> !o_m_tdata[4] && !o_m_tdata[37] && o_m_tlast)
        else $error("hit result with writeback or load");

    // Writeback address is zero unless a writeback is asked for.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[4] |-> o_m_tdata[36:5] == 32'd0)
        else $error("writeback address without writeback");

    // No new request is taken while a flush is still reporting ways.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("request taken during flush");

    // A real command closes the request port once it has been taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tdata[1:0] != CMD_NONE) |=> !o_s_tready)
        else $error("request port stayed open");

endmodule

bind lru_block_cache_directory_unit lbcd_checker u_lbcd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
